>>> hdl/temperature_frame_checker_macros.svh
// Assertion helpers shared by the frame checker modules.
`ifndef TEMPERATURE_FRAME_CHECKER_MACROS_SVH
`define TEMPERATURE_FRAME_CHECKER_MACROS_SVH

// Checked at every rising edge, including the edges while reset is held.
`define TFC_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while reset is released.
`define TFC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

>>> hdl/tfc_pkg.sv
package tfc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned TEMP_W  = 16;
    localparam logic [7:0]  CRC_POLY_REFL = 8'h8C;
    localparam logic [15:0] POWER_ON_RAW  = 16'h0550;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NODEV   = 2'd1,
        ST_CRC     = 2'd2,
        ST_POWERON = 2'd3
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              link_ok;
    } t_in_item;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_q4;
        t_status                  frame_status;
    } t_out_item;

endpackage

>>> hdl/tfc_stream_if.sv
interface tfc_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/tfc_crc8.sv
module tfc_crc8 (
    input  logic [7:0] i_crc,
    input  logic [7:0] i_data,
    output logic [7:0] o_crc
);

    // Reflected 1-Wire CRC, one data bit per step, LSB first.
    always_comb begin
        logic [7:0] crc;
        logic [7:0] data;
        crc  = i_crc;
        data = i_data;
        for (int k = 0; k < 8; k++) begin
            if (crc[0] ^ data[0]) begin
                crc = (crc >> 1) ^ tfc_pkg::CRC_POLY_REFL;
            end else begin
                crc = crc >> 1;
            end
            data = data >> 1;
        end
        o_crc = crc;
    end

endmodule

>>> hdl/tfc_frame.sv
`include "temperature_frame_checker_macros.svh"

module tfc_frame #(
    parameter int unsigned FRAME_BYTES = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  tfc_pkg::t_in_item   i_item,
    output logic                o_has_result,
    output tfc_pkg::t_out_item  o_result
);

    localparam int unsigned IDX_W = $clog2(FRAME_BYTES);

    logic [IDX_W-1:0] r_idx, n_idx;
    logic [7:0]       r_crc, n_crc;
    logic [7:0]       r_lo, n_lo;
    logic [7:0]       r_hi, n_hi;
    logic [7:0]       crc_upd;
    logic             last;
    logic [15:0]      raw;

    tfc_crc8 u_crc8 (
        .i_crc  (r_crc),
        .i_data (i_item.rx_byte),
        .o_crc  (crc_upd)
    );

    assign last = ({1'b0, r_idx} + (IDX_W+1)'(1)) >= (IDX_W+1)'(FRAME_BYTES);
    assign o_has_result = !i_item.link_ok || last;

    // The temperature word is taken from the byte arriving now when the
    // frame is so short that the high byte lands on the last position.
    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (r_idx == IDX_W'(0)) begin
            n_lo = i_item.rx_byte;
        end else if (r_idx == IDX_W'(1)) begin
            n_hi = i_item.rx_byte;
        end
        raw = {n_hi, n_lo};

        o_result.temp_q4      = '0;
        o_result.frame_status = tfc_pkg::ST_OK;
        priority if (!i_item.link_ok) begin
            o_result.frame_status = tfc_pkg::ST_NODEV;
        end else if (crc_upd != 8'h00) begin
            o_result.frame_status = tfc_pkg::ST_CRC;
        end else if (raw == tfc_pkg::POWER_ON_RAW) begin
            o_result.frame_status = tfc_pkg::ST_POWERON;
        end else begin
            o_result.temp_q4 = signed'(raw);
        end

        if (o_has_result) begin
            n_idx = '0;
            n_crc = '0;
            n_lo  = '0;
            n_hi  = '0;
        end else begin
            n_idx = r_idx + IDX_W'(1);
            n_crc = crc_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_crc <= '0;
            r_lo  <= '0;
            r_hi  <= '0;
        end else if (i_step) begin
            r_idx <= n_idx;
            r_crc <= n_crc;
            r_lo  <= n_lo;
            r_hi  <= n_hi;
        end
    end

    `TFC_ASSERT_RST(a_idx_in_frame, i_clk, i_rst_n, ({1'b0, r_idx} < (IDX_W+1)'(FRAME_BYTES)), "byte index ran past the frame")
    `TFC_ASSERT_RST(a_abort_clears, i_clk, i_rst_n, (i_step && !i_item.link_ok |=> r_idx == '0 && r_crc == 8'h00), "link loss did not clear the frame")

endmodule

>>> hdl/temperature_frame_checker.sv
// Checks temperature sensor scratchpad frames of FRAME_BYTES bytes, one byte
// per input transfer. Each byte lands in an input register and is folded into
// the CRC and the frame state when it advances, which also loads the result
// register, so a byte can be accepted every cycle unless a held result stalls
// it. A frame's last byte passes through the input register, and its result
// is then loaded into the result register and offered from there. The output
// register holds a result until it is taken; new bytes keep flowing while it
// waits unless the byte in the input register would produce the next result.
// A byte with link_ok clear aborts the frame and gives a no-device result at
// once. temp_q4 is the raw sensor word in 1/16 degree and reads 0 unless the
// status is ok.
`include "temperature_frame_checker_macros.svh"

module temperature_frame_checker #(
    parameter int unsigned FRAME_BYTES = 9
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tfc_stream_if.sink   i_in,
    tfc_stream_if.source o_out
);

    logic                r_in_valid;
    tfc_pkg::t_in_item   r_in_item;
    logic                r_out_valid;
    tfc_pkg::t_out_item  r_out_item;
    logic                advance;
    logic                has_result;
    tfc_pkg::t_out_item  result;

    tfc_frame #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_item       (r_in_item),
        .o_has_result (has_result),
        .o_result     (result)
    );

    assign advance    = r_in_valid && (!has_result || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_result) begin
            r_out_item <= result;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_item;

    `TFC_ASSERT(a_reset_empty, i_clk, (!i_rst_n |=> !r_in_valid && !r_out_valid), "pipeline not empty after reset")
    `TFC_ASSERT_RST(a_in_hold, i_clk, i_rst_n, (r_in_valid && !advance |=> r_in_valid && $stable(r_in_item)), "stalled input byte was lost")
    `TFC_ASSERT_RST(a_out_hold, i_clk, i_rst_n, (r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out_item)), "pending result was overwritten")
    `TFC_ASSERT_RST(a_temp_zero, i_clk, i_rst_n, (r_out_valid && r_out_item.frame_status != tfc_pkg::ST_OK |-> r_out_item.temp_q4 == 16'sd0), "temperature not zero on a failed frame")

endmodule

>>> tb/sv/tfc_tb_pkg.sv
package tfc_tb_pkg;

    // One byte of the 1-Wire CRC-8 in its reflected form, least significant bit first.
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        logic [7:0] d;
        logic       fb;
        crc = crc_in;
        d   = data;
        for (int k = 0; k < 8; k++) begin
            fb  = crc[0] ^ d[0];
            crc = crc >> 1;
            if (fb) begin
                crc = crc ^ tfc_pkg::CRC_POLY_REFL;
            end
            d = d >> 1;
        end
        return crc;
    endfunction

endpackage

>>> tb/sv/tfc_frame_monitor.sv
module tfc_frame_monitor #(
    parameter int unsigned FRAME_LEN = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  tfc_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  tfc_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_status_hits [4]
);

    logic [3:0]         frame_pos;
    logic [7:0]         crc_run;
    logic [7:0]         temp_lo;
    logic [7:0]         temp_hi;
    tfc_pkg::t_out_item due_results [$];

    task automatic report_mismatch(input string what);
        $display("[%0t] frame result mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic clear_frame();
        frame_pos = '0;
        crc_run   = '0;
        temp_lo   = '0;
        temp_hi   = '0;
    endtask

    // Folds one accepted byte into the frame and queues the result it closes, if any.
    task automatic fold_byte(input tfc_pkg::t_in_item item);
        tfc_pkg::t_out_item res;
        logic [15:0]        word;
        if (!item.link_ok) begin
            clear_frame();
            res.temp_q4      = '0;
            res.frame_status = tfc_pkg::ST_NODEV;
            due_results.push_back(res);
            return;
        end
        crc_run = tfc_tb_pkg::crc8_fold(crc_run, item.rx_byte);
        if (frame_pos == 4'd0) begin
            temp_lo = item.rx_byte;
        end else if (frame_pos == 4'd1) begin
            temp_hi = item.rx_byte;
        end
        if (int'(frame_pos) + 1 < int'(FRAME_LEN)) begin
            frame_pos = frame_pos + 4'd1;
            return;
        end
        word = {temp_hi, temp_lo};
        if (crc_run != 8'd0) begin
            res.temp_q4      = '0;
            res.frame_status = tfc_pkg::ST_CRC;
        end else if (word == tfc_pkg::POWER_ON_RAW) begin
            res.temp_q4      = '0;
            res.frame_status = tfc_pkg::ST_POWERON;
        end else begin
            res.temp_q4      = signed'(word);
            res.frame_status = tfc_pkg::ST_OK;
        end
        due_results.push_back(res);
        clear_frame();
    endtask

    always @(posedge i_clk) begin : watch
        tfc_pkg::t_out_item want;
        if (!i_rst_n) begin
            clear_frame();
            due_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                fold_byte(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result temp_q4=%0d status=%0d",
                        i_out_data.temp_q4, i_out_data.frame_status));
                end else begin
                    want = due_results.pop_front();
                    o_status_hits[want.frame_status]++;
                    if (i_out_data.temp_q4 !== want.temp_q4) begin
                        report_mismatch($sformatf("temp_q4 got %0d expected %0d",
                            i_out_data.temp_q4, want.temp_q4));
                    end
                    if (i_out_data.frame_status !== want.frame_status) begin
                        report_mismatch($sformatf("frame_status got %0d expected %0d",
                            i_out_data.frame_status, want.frame_status));
                    end
                end
            end
        end
        o_pending = due_results.size();
    end

endmodule

>>> tb/sv/temperature_frame_checker_tb.sv
module temperature_frame_checker_tb;

    localparam int FRAME_LEN     = 9;
    localparam int TARGET_BYTES  = 2000;
    localparam int CYCLE_LIMIT   = 500_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 200;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int fail_count;
    int results_due;
    int status_hits [4];
    int cycle_count;
    int bytes_sent;
    int link_drops;
    int frame_fill;
    int src_mode;
    int sink_mode;
    int hold_requests;
    int holds_done;

    tfc_stream_if #(.t_payload(tfc_pkg::t_in_item))  byte_ch ();
    tfc_stream_if #(.t_payload(tfc_pkg::t_out_item)) result_ch ();

    temperature_frame_checker #(
        .FRAME_BYTES(FRAME_LEN)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (byte_ch),
        .o_out  (result_ch)
    );

    tfc_frame_monitor #(
        .FRAME_LEN(FRAME_LEN)
    ) mon (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (byte_ch.valid),
        .i_in_ready   (byte_ch.ready),
        .i_in_data    (byte_ch.payload),
        .i_out_valid  (result_ch.valid),
        .i_out_ready  (result_ch.ready),
        .i_out_data   (result_ch.payload),
        .o_fail_count (fail_count),
        .o_pending    (results_due),
        .o_status_hits(status_hits)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("temperature_frame_checker test failed");
            $finish;
        end
    end

    // Mode 0 never idles, mode 1 idles freely, mode 2 idles now and then.
    function automatic int draw_wait(input int mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 18);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic link);
        int gap;
        gap = draw_wait(src_mode);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.payload <= tfc_pkg::t_in_item'{rx_byte: b, link_ok: link};
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        bytes_sent++;
        if (link) begin
            frame_fill = (frame_fill + 1) % FRAME_LEN;
        end else begin
            frame_fill = 0;
            link_drops++;
        end
    endtask

    // Frame ending in its CRC (corrupt flips a bit); link drop replaces byte abort_at.
    task automatic send_frame(input logic [15:0] word, input bit corrupt, input int abort_at);
        logic [7:0] body [0:FRAME_LEN-1];
        logic [7:0] crc;
        while (frame_fill != 0) push_byte(8'($urandom), 1'b1);
        body[0] = word[7:0];
        body[1] = word[15:8];
        for (int k = 2; k < FRAME_LEN - 1; k++) body[k] = 8'($urandom);
        crc = '0;
        for (int k = 0; k < FRAME_LEN - 1; k++) crc = tfc_tb_pkg::crc8_fold(crc, body[k]);
        body[FRAME_LEN-1] = crc;
        if (corrupt) begin
            body[$urandom_range(0, FRAME_LEN - 1)] ^= 8'(1 << $urandom_range(0, 7));
        end
        for (int k = 0; k < FRAME_LEN; k++) begin
            if (k == abort_at) begin
                push_byte(8'($urandom), 1'b0);
                return;
            end
            push_byte(body[k], 1'b1);
        end
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0: return tfc_pkg::POWER_ON_RAW;
            1: return 16'h8000;
            2: return 16'h7FFF;
            3: return 16'h0000;
            4: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic wait_results_drained();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int hold;
        int taken;
        taken = 0;
        result_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken % 40 == 0) begin
                sink_mode = $urandom_range(0, 2);
            end
            if (hold_requests != holds_done) begin
                holds_done++;
                hold = LONG_HOLD;
            end else begin
                hold = draw_wait(sink_mode);
            end
            if (hold > 0) begin
                result_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!result_ch.valid) @(posedge i_clk);
            taken++;
        end
    end

    initial begin
        int  roll;
        int  noise_len;
        bit  burst_done;
        bit  pause_done;
        burst_done = 1'b0;
        pause_done = 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.payload <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a link drop outside any frame, the power-on word, the most
        // negative reading, and a frame cut short after two bytes.
        src_mode = $urandom_range(0, 2);
        push_byte(8'hA5, 1'b0);
        send_frame(tfc_pkg::POWER_ON_RAW, 1'b0, FRAME_LEN);
        send_frame(16'h8000, 1'b0, FRAME_LEN);
        send_frame(16'h1234, 1'b0, 2);

        while (bytes_sent < TARGET_BYTES) begin
            src_mode = $urandom_range(0, 2);
            if (!burst_done && bytes_sent >= 600) begin
                // The receiver holds off while link drops pile up results, so the
                // block fills and has to refuse further transfers.
                burst_done = 1'b1;
                src_mode   = 0;
                hold_requests++;
                for (int k = 0; k < 24; k++) push_byte(8'($urandom), 1'b0);
                send_frame(pick_word(), 1'b0, FRAME_LEN);
                send_frame(pick_word(), 1'b0, FRAME_LEN);
            end
            if (!pause_done && bytes_sent >= 1300) begin
                pause_done = 1'b1;
                wait_results_drained();
            end
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
                send_frame(pick_word(), $urandom_range(0, 4) == 0, FRAME_LEN);
            end else if (roll < 88) begin
                send_frame(pick_word(), 1'b0, $urandom_range(0, FRAME_LEN - 1));
            end else begin
                noise_len = $urandom_range(1, 12);
                for (int k = 0; k < noise_len; k++) begin
                    push_byte(8'($urandom), $urandom_range(0, 5) != 0);
                end
            end
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d bytes, %0d with the link down, in %0d cycles.",
            bytes_sent, link_drops, cycle_count);
        $display("Results seen: %0d ok, %0d no device, %0d CRC error, %0d power-on.",
            status_hits[tfc_pkg::ST_OK], status_hits[tfc_pkg::ST_NODEV],
            status_hits[tfc_pkg::ST_CRC], status_hits[tfc_pkg::ST_POWERON]);
        if (fail_count == 0 && results_due == 0) begin
            $display("temperature_frame_checker test passed");
        end else begin
            $display("temperature_frame_checker test failed");
        end
        $finish;
    end

endmodule
